// ----- design/ttc_pkg.sv -----
// Shared types, codes and constants of the TFTP transfer controller.
// No dependencies; every design file imports it.
package ttc_pkg;

  localparam int unsigned MAX_RESULTS     = 3;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam logic [9:0]  BLOCK_BYTES = 10'd512;
  localparam logic [9:0]  HDR_BYTES   = 10'd4;
  localparam logic [15:0] FIRST_BLOCK = 16'd1;
  localparam logic [3:0]  RETRY_SAT   = 4'd15;
  localparam logic [3:0]  RETRY_LIMIT_RST = 4'd5;

  // event kinds
  localparam logic [1:0] OP_PACKET  = 2'd0;
  localparam logic [1:0] OP_TIMEOUT = 2'd1;
  localparam logic [1:0] OP_CHUNK   = 2'd2;

  // received opcodes
  localparam logic [7:0] OPC_RRQ   = 8'd1;
  localparam logic [7:0] OPC_WRQ   = 8'd2;
  localparam logic [7:0] OPC_DATA  = 8'd3;
  localparam logic [7:0] OPC_ACK   = 8'd4;
  localparam logic [7:0] OPC_ERROR = 8'd5;

  typedef enum logic [3:0] {
    ACT_DATA       = 4'd0,
    ACT_ACK        = 4'd1,
    ACT_ERROR      = 4'd2,
    ACT_CHUNK      = 4'd3,
    ACT_WRITE      = 4'd4,
    ACT_DONE       = 4'd5,
    ACT_AB_RETRIES = 4'd6,
    ACT_AB_BLOCK   = 4'd7,
    ACT_AB_OPCODE  = 4'd8,
    ACT_AB_PEER    = 4'd9,
    ACT_AB_OPEN    = 4'd10
  } action_t;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'b0001,
    PH_WAIT_CHUNK = 4'b0010,
    PH_WAIT_ACK   = 4'b0100,
    PH_WRITE      = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  pkt_opcode;
    logic [15:0] pkt_block;
    logic [9:0]  pkt_length;
    logic [9:0]  chunk_length;
    logic        file_ok;
  } in_item_t;

  typedef struct packed {
    action_t     action;
    logic [15:0] packet_block;
    logic [9:0]  payload_length;
    logic        last;
  } out_item_t;

  typedef struct packed {
    action_t     action;
    logic [15:0] blk;
    logic [9:0]  len;
  } res_t;

  // all results of one event; cnt is 1 to 3 for a queued bundle
  typedef struct packed {
    logic [1:0]                  cnt;
    res_t [MAX_RESULTS-1:0]      res;
  } bundle_t;

  function automatic res_t mk_res(action_t act, logic [15:0] blk, logic [9:0] len);
    res_t r;
    r.action = act;
    r.blk    = blk;
    r.len    = len;
    return r;
  endfunction

endpackage

// ----- design/tftp_transfer_controller.sv -----
// Top level of the server-side TFTP transfer controller.
// Depends on ttc_pkg, ttc_front, ttc_queue and ttc_back.

// Server-side TFTP transfer controller. Each input beat is one event: a received
// packet, a receive timeout, or a file chunk becoming ready. The front end decides
// the whole reaction of an event in the cycle it is accepted (one event per cycle
// while the queue has room) and writes the zero to three resulting actions as one
// bundle into a queue of QUEUE_DEPTH bundles; events with no reaction leave no trace
// in the queue. The back end reads bundles and sends one result beat per cycle,
// while out_ready allows, through an output register, so an event holds the result
// port for one beat per result and the result rate, not the decision logic, sets
// sustained throughput. With the queue and the output register empty, an accepted
// event is written into the queue, and its first result goes from the queue into
// the output register, raising out_valid. The final beat of each event carries
// last. The retry limit is written through the cfg port, which is always ready;
// write it only while no results are pending.
module tftp_transfer_controller #(
  parameter int unsigned QUEUE_DEPTH = ttc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ttc_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ttc_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_data
);
  import ttc_pkg::*;

  logic [3:0] retry_limit_r;
  logic       q_push, q_pop, q_full, q_valid;
  bundle_t    q_push_bnd, q_head;

  // Config register: always take the write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      retry_limit_r <= RETRY_LIMIT_RST;
    end else if (cfg_valid) begin
      retry_limit_r <= cfg_data;
    end
  end

  // Decide each event's reaction and advance the transfer state.
  ttc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .retry_limit (retry_limit_r),
    .q_full      (q_full),
    .push        (q_push),
    .push_bnd    (q_push_bnd)
  );

  // Hold decided bundles so either side can stall on its own.
  ttc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_bnd  (q_push_bnd),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  // Drain bundles one result beat at a time.
  ttc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .head      (q_head),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- design/ttc_front.sv -----
// Front end: accepts events, holds the transfer state and decides the results.
// Depends on ttc_pkg.
module ttc_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ttc_pkg::in_item_t in_data,
  input  logic [3:0]        retry_limit,
  input  logic              q_full,
  output logic              push,
  output ttc_pkg::bundle_t  push_bnd
);
  import ttc_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [15:0] blk_r, blk_nxt;
  logic [3:0]  retry_r, retry_nxt;
  logic [9:0]  held_r, held_nxt;

  bundle_t     bnd;
  logic        go_idle;
  logic        in_fire;
  logic [15:0] blk_inc;
  logic [3:0]  retry_inc;
  logic [9:0]  pay_raw, pay, chunk;

  assign in_ready = !q_full;
  assign in_fire  = in_valid && in_ready;
  assign push     = in_fire && (bnd.cnt != 2'd0);
  assign push_bnd = bnd;

  always_comb begin
    phase_nxt = phase_r;
    blk_nxt   = blk_r;
    retry_nxt = retry_r;
    held_nxt  = held_r;
    bnd       = '0;
    go_idle   = 1'b0;
    blk_inc   = blk_r + 16'd1;
    retry_inc = (retry_r == RETRY_SAT) ? RETRY_SAT : retry_r + 4'd1;
    pay_raw   = (in_data.pkt_length >= HDR_BYTES) ? in_data.pkt_length - HDR_BYTES : 10'd0;
    pay       = (pay_raw > BLOCK_BYTES) ? BLOCK_BYTES : pay_raw;
    chunk     = (in_data.chunk_length > BLOCK_BYTES) ? BLOCK_BYTES : in_data.chunk_length;

    if (in_data.op == OP_PACKET) begin
      if (phase_r == PH_IDLE) begin
        if (in_data.pkt_opcode == OPC_RRQ || in_data.pkt_opcode == OPC_WRQ) begin
          priority if (!in_data.file_ok) begin
            bnd.cnt    = 2'd2;
            bnd.res[0] = mk_res(ACT_ERROR, 16'd0, 10'd0);
            bnd.res[1] = mk_res(ACT_AB_OPEN, 16'd0, 10'd0);
            go_idle    = 1'b1;
          end else if (in_data.pkt_opcode == OPC_RRQ) begin
            phase_nxt  = PH_WAIT_CHUNK;
            bnd.cnt    = 2'd1;
            bnd.res[0] = mk_res(ACT_CHUNK, FIRST_BLOCK, 10'd0);
          end else begin
            phase_nxt  = PH_WRITE;
            bnd.cnt    = 2'd1;
            bnd.res[0] = mk_res(ACT_ACK, 16'd0, 10'd0);
          end
        end else if (in_data.pkt_opcode != OPC_ACK) begin
          bnd.cnt    = 2'd1;
          bnd.res[0] = mk_res(ACT_AB_OPCODE, 16'd0, 10'd0);
          go_idle    = 1'b1;
        end
      end else if (in_data.pkt_opcode == OPC_ERROR) begin
        bnd.cnt    = 2'd1;
        bnd.res[0] = mk_res(ACT_AB_PEER, 16'd0, 10'd0);
        go_idle    = 1'b1;
      end else if (phase_r == PH_WAIT_ACK) begin
        priority if (in_data.pkt_opcode != OPC_ACK) begin
          bnd.cnt    = 2'd1;
          bnd.res[0] = mk_res(ACT_AB_OPCODE, 16'd0, 10'd0);
          go_idle    = 1'b1;
        end else if (in_data.pkt_block == blk_r) begin
          bnd.cnt = 2'd1;
          if (held_r < BLOCK_BYTES) begin
            bnd.res[0] = mk_res(ACT_DONE, 16'd0, 10'd0);
            go_idle    = 1'b1;
          end else begin
            blk_nxt    = blk_inc;
            retry_nxt  = 4'd0;
            phase_nxt  = PH_WAIT_CHUNK;
            bnd.res[0] = mk_res(ACT_CHUNK, blk_inc, 10'd0);
          end
        end else if (in_data.pkt_block < blk_r) begin
          retry_nxt  = 4'd0;
          bnd.cnt    = 2'd1;
          bnd.res[0] = mk_res(ACT_DATA, blk_r, held_r);
        end else begin
          bnd.cnt    = 2'd1;
          bnd.res[0] = mk_res(ACT_AB_BLOCK, 16'd0, 10'd0);
          go_idle    = 1'b1;
        end
      end else if (phase_r == PH_WRITE) begin
        if (in_data.pkt_opcode != OPC_DATA) begin
          bnd.cnt    = 2'd1;
          bnd.res[0] = mk_res(ACT_AB_OPCODE, 16'd0, 10'd0);
          go_idle    = 1'b1;
        end else if (in_data.pkt_block == blk_r) begin
          bnd.res[0] = mk_res(ACT_WRITE, blk_r, pay);
          bnd.res[1] = mk_res(ACT_ACK, blk_r, 10'd0);
          if (pay < BLOCK_BYTES) begin
            bnd.cnt    = 2'd3;
            bnd.res[2] = mk_res(ACT_DONE, 16'd0, 10'd0);
            go_idle    = 1'b1;
          end else begin
            bnd.cnt   = 2'd2;
            blk_nxt   = blk_inc;
            retry_nxt = 4'd0;
          end
        end else if (in_data.pkt_block > blk_r) begin
          bnd.cnt    = 2'd1;
          bnd.res[0] = mk_res(ACT_AB_BLOCK, 16'd0, 10'd0);
          go_idle    = 1'b1;
        end
      end
    end else if (in_data.op == OP_TIMEOUT) begin
      if (phase_r == PH_WAIT_ACK || phase_r == PH_WRITE) begin
        retry_nxt = retry_inc;
        if (retry_inc >= retry_limit) begin
          bnd.cnt    = 2'd1;
          bnd.res[0] = mk_res(ACT_AB_RETRIES, 16'd0, 10'd0);
          go_idle    = 1'b1;
        end else if (phase_r == PH_WAIT_ACK) begin
          bnd.cnt    = 2'd1;
          bnd.res[0] = mk_res(ACT_DATA, blk_r, held_r);
        end
      end
    end else if (in_data.op == OP_CHUNK) begin
      if (phase_r == PH_WAIT_CHUNK) begin
        held_nxt   = chunk;
        retry_nxt  = 4'd0;
        phase_nxt  = PH_WAIT_ACK;
        bnd.cnt    = 2'd1;
        bnd.res[0] = mk_res(ACT_DATA, blk_r, chunk);
      end
    end

    // every return to idle restarts the whole context
    if (go_idle) begin
      phase_nxt = PH_IDLE;
      blk_nxt   = FIRST_BLOCK;
      retry_nxt = 4'd0;
      held_nxt  = 10'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      blk_r   <= FIRST_BLOCK;
      retry_r <= 4'd0;
      held_r  <= 10'd0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      blk_r   <= blk_nxt;
      retry_r <= retry_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

// ----- design/ttc_queue.sv -----
// Short bundle queue between the decision front end and the result back end.
// Depends on ttc_pkg.
module ttc_queue #(
  parameter int unsigned DEPTH = ttc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ttc_pkg::bundle_t push_bnd,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output ttc_pkg::bundle_t head
);
  import ttc_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  bundle_t            slot_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_bnd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ----- design/ttc_back.sv -----
// Back end: unpacks queued bundles into single result beats, output register.
// Depends on ttc_pkg.
module ttc_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  ttc_pkg::bundle_t   head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output ttc_pkg::out_item_t out_data
);
  import ttc_pkg::*;

  logic [1:0] idx_r;
  logic       out_valid_r;
  out_item_t  out_data_r;
  logic       load;
  logic       is_last;
  res_t       cur;

  assign load    = q_valid && (!out_valid_r || out_ready);
  assign cur     = head.res[idx_r];
  assign is_last = (idx_r == head.cnt - 2'd1);
  assign pop     = load && is_last;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r.action         <= cur.action;
      out_data_r.packet_block   <= cur.blk;
      out_data_r.payload_length <= cur.len;
      out_data_r.last           <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (load) begin
        idx_r <= is_last ? 2'd0 : idx_r + 2'd1;
      end
    end
  end

endmodule

// ----- dv/tftp_action_checker.sv -----
// Result checker for the TFTP transfer controller: tracks the transfer state
// from the accepted events and register writes and compares every result beat.
// Depends on ttc_pkg for the channel structs, opcodes, actions and phases.
module tftp_action_checker
  import ttc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [3:0]  cfg_data,
  output int unsigned actions_pending,
  output int unsigned mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;

  phase_t      xfer_phase;
  logic [15:0] cur_block;
  logic [3:0]  retries;
  logic [9:0]  held_len;
  logic [3:0]  retry_limit;

  out_item_t   expected_actions[$];

  function automatic void add_action(action_t act, logic [15:0] blk, logic [9:0] len);
    out_item_t beat;
    beat.action         = act;
    beat.packet_block   = blk;
    beat.payload_length = len;
    beat.last           = 1'b0;
    expected_actions.push_back(beat);
  endfunction

  function automatic void return_to_idle();
    xfer_phase = PH_IDLE;
    cur_block  = FIRST_BLOCK;
    retries    = '0;
    held_len   = '0;
  endfunction

  function automatic void abort_transfer(action_t act);
    add_action(act, '0, '0);
    return_to_idle();
  endfunction

  // Work out every action one event causes and queue them in order.
  function automatic void predict_reaction(in_item_t ev);
    int unsigned queued_prior;
    int unsigned pay;
    int unsigned tries;
    out_item_t   tail;
    queued_prior = expected_actions.size();
    case (ev.op)
      OP_PACKET: begin
        if (xfer_phase == PH_IDLE) begin
          if (ev.pkt_opcode == OPC_RRQ || ev.pkt_opcode == OPC_WRQ) begin
            if (!ev.file_ok) begin
              add_action(ACT_ERROR, '0, '0);
              abort_transfer(ACT_AB_OPEN);
            end else if (ev.pkt_opcode == OPC_RRQ) begin
              return_to_idle();
              xfer_phase = PH_WAIT_CHUNK;
              add_action(ACT_CHUNK, cur_block, '0);
            end else begin
              return_to_idle();
              xfer_phase = PH_WRITE;
              add_action(ACT_ACK, '0, '0);
            end
          end else if (ev.pkt_opcode != OPC_ACK) begin
            abort_transfer(ACT_AB_OPCODE);
          end
        end else if (ev.pkt_opcode == OPC_ERROR) begin
          abort_transfer(ACT_AB_PEER);
        end else if (xfer_phase == PH_WAIT_ACK) begin
          if (ev.pkt_opcode != OPC_ACK) begin
            abort_transfer(ACT_AB_OPCODE);
          end else if (ev.pkt_block == cur_block) begin
            if (held_len < BLOCK_BYTES) begin
              abort_transfer(ACT_DONE);
            end else begin
              cur_block  = cur_block + 16'd1;
              retries    = '0;
              xfer_phase = PH_WAIT_CHUNK;
              add_action(ACT_CHUNK, cur_block, '0);
            end
          end else if (ev.pkt_block < cur_block) begin
            retries = '0;
            add_action(ACT_DATA, cur_block, held_len);
          end else begin
            abort_transfer(ACT_AB_BLOCK);
          end
        end else if (xfer_phase == PH_WRITE) begin
          if (ev.pkt_opcode != OPC_DATA) begin
            abort_transfer(ACT_AB_OPCODE);
          end else if (ev.pkt_block == cur_block) begin
            pay = (ev.pkt_length >= HDR_BYTES) ? ev.pkt_length - HDR_BYTES : 0;
            if (pay > BLOCK_BYTES) pay = BLOCK_BYTES;
            add_action(ACT_WRITE, cur_block, 10'(pay));
            add_action(ACT_ACK, cur_block, '0);
            if (pay < BLOCK_BYTES) begin
              abort_transfer(ACT_DONE);
            end else begin
              cur_block = cur_block + 16'd1;
              retries   = '0;
            end
          end else if (ev.pkt_block > cur_block) begin
            abort_transfer(ACT_AB_BLOCK);
          end
        end
      end
      OP_TIMEOUT: begin
        if (xfer_phase == PH_WAIT_ACK || xfer_phase == PH_WRITE) begin
          tries = retries + 1;
          if (tries > RETRY_SAT) tries = RETRY_SAT;
          retries = 4'(tries);
          if (tries >= retry_limit) begin
            abort_transfer(ACT_AB_RETRIES);
          end else if (xfer_phase == PH_WAIT_ACK) begin
            add_action(ACT_DATA, cur_block, held_len);
          end
        end
      end
      OP_CHUNK: begin
        if (xfer_phase == PH_WAIT_CHUNK) begin
          held_len   = (ev.chunk_length > BLOCK_BYTES) ? BLOCK_BYTES : ev.chunk_length;
          retries    = '0;
          xfer_phase = PH_WAIT_ACK;
          add_action(ACT_DATA, cur_block, held_len);
        end
      end
      default: begin
      end
    endcase
    if (expected_actions.size() > queued_prior) begin
      tail      = expected_actions.pop_back();
      tail.last = 1'b1;
      expected_actions.push_back(tail);
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      retry_limit = RETRY_LIMIT_RST;
      return_to_idle();
      expected_actions.delete();
    end else begin
      // compare before predicting: a beat never answers an event of the same edge
      if (out_valid && out_ready) begin
        if (expected_actions.size() == 0) begin
          $error("unexpected result beat: action %0d block %0d length %0d last %0b",
                 out_data.action, out_data.packet_block, out_data.payload_length,
                 out_data.last);
          mismatch_count++;
        end else begin
          want = expected_actions.pop_front();
          if (out_data.action !== want.action) begin
            $error("action: expected %0d, got %0d", want.action, out_data.action);
            mismatch_count++;
          end
          if (out_data.packet_block !== want.packet_block) begin
            $error("packet_block: expected %0d, got %0d",
                   want.packet_block, out_data.packet_block);
            mismatch_count++;
          end
          if (out_data.payload_length !== want.payload_length) begin
            $error("payload_length: expected %0d, got %0d",
                   want.payload_length, out_data.payload_length);
            mismatch_count++;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_data.last);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) predict_reaction(in_data);
      if (cfg_valid && cfg_ready) retry_limit = cfg_data;
    end
    actions_pending <= expected_actions.size();
  end

endmodule

// ----- dv/tb_tftp_transfer_controller.sv -----
// Testbench top for the TFTP transfer controller: drives events, register
// writes and result backpressure, and gives the verdict.
// Depends on ttc_pkg, tftp_transfer_controller and tftp_action_checker.
module tb_tftp_transfer_controller;
  import ttc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // op code that no event uses; the block must drop it in every phase
  localparam logic [1:0]  OP_UNUSED     = 2'd3;
  localparam logic [9:0]  FULL_PACKET   = BLOCK_BYTES + HDR_BYTES;
  localparam int unsigned SETTLE_CYCLES = 6;     // event-to-result latency plus margin
  localparam int unsigned HOLD_CYCLES   = 120;   // long receiver hold-off
  localparam int unsigned DRAIN_LIMIT   = 4000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_data;

  int unsigned actions_pending;
  int unsigned mismatch_count;

  // stimulus knobs shared between the sender and the receiver process
  int unsigned events_sent;
  int unsigned send_gap_pct;
  int unsigned stall_pct;
  logic [3:0]  retry_limit_cfg;
  bit          hold_request;
  bit          receiver_holding;

  tftp_transfer_controller dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  tftp_action_checker action_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .actions_pending (actions_pending),
    .mismatch_count  (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #1ms;
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Event builders. Fields the block ignores for a given event are randomized so
  // that every input bit toggles without changing the expected reaction.
  // ---------------------------------------------------------------------------
  function automatic in_item_t ev_request(logic [7:0] opc, logic ok);
    return {OP_PACKET, opc, 16'($urandom), 10'($urandom), 10'($urandom), ok};
  endfunction

  function automatic in_item_t ev_packet(logic [7:0] opc, logic [15:0] blk);
    return {OP_PACKET, opc, blk, 10'($urandom), 10'($urandom), 1'($urandom)};
  endfunction

  function automatic in_item_t ev_data(logic [15:0] blk, logic [9:0] plen);
    return {OP_PACKET, OPC_DATA, blk, plen, 10'($urandom), 1'($urandom)};
  endfunction

  function automatic in_item_t ev_timeout();
    return {OP_TIMEOUT, 8'($urandom), 16'($urandom), 10'($urandom), 10'($urandom),
            1'($urandom)};
  endfunction

  function automatic in_item_t ev_chunk(logic [9:0] clen);
    return {OP_CHUNK, 8'($urandom), 16'($urandom), 10'($urandom), clen, 1'($urandom)};
  endfunction

  // Anything at all, unused op code included; opcodes lean toward the known ones.
  function automatic in_item_t rand_event();
    logic [7:0] opc;
    opc = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 6));
    return {2'($urandom), opc, 16'($urandom), 10'($urandom), 10'($urandom), 1'($urandom)};
  endfunction

  function automatic logic [7:0] other_opcode(logic [7:0] excluded);
    logic [7:0] opc;
    do opc = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 6));
    while (opc == excluded);
    return opc;
  endfunction

  // Chunk size: full (now and then oversized) mid-file, short on the final block.
  function automatic logic [9:0] pick_chunk_len(bit final_block);
    if (final_block) return ($urandom_range(0, 9) == 0) ? 10'd0 : 10'($urandom_range(1, 511));
    return ($urandom_range(0, 7) == 0) ? 10'($urandom_range(513, 1023)) : BLOCK_BYTES;
  endfunction

  // Packet size: short (now and then below the header) on the final block,
  // full or oversized otherwise.
  function automatic logic [9:0] pick_packet_len(bit final_block);
    if (final_block)
      return ($urandom_range(0, 7) == 0) ? 10'($urandom_range(0, 3))
                                         : 10'($urandom_range(4, 515));
    return ($urandom_range(0, 7) == 0) ? 10'($urandom_range(517, 1023)) : FULL_PACKET;
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------

  // Offer one event beat and hold it until accepted. Valid drops only when a
  // gap is inserted, so back-to-back beats keep valid high.
  task automatic put_event(input in_item_t ev);
    if (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_data  <= ev;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    events_sent++;
  endtask

  // Stop offering and wait until every predicted beat is out, then let the
  // pipeline settle so that events without results have cleared too.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (actions_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_retry_limit(logic [3:0] limit);
    settle();
    cfg_data  <= limit;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    retry_limit_cfg = limit;
  endtask

  // ---------------------------------------------------------------------------
  // Transfer sequences
  // ---------------------------------------------------------------------------

  // Read transfer: chunk, DATA, ACK per block, with duplicate ACKs, timeouts,
  // stray noise and now and then a deliberate abort.
  task automatic read_session();
    logic [15:0] blk;
    int unsigned nblk;
    int unsigned tries;
    bit          ok;
    ok = ($urandom_range(0, 9) != 0);
    put_event(ev_request(OPC_RRQ, ok));
    if (!ok) return;
    blk  = FIRST_BLOCK;
    nblk = $urandom_range(1, 5);
    for (int i = 1; i <= nblk; i++) begin
      // a timeout while the file is still being read is dropped
      if ($urandom_range(0, 9) == 0) put_event(ev_timeout());
      if ($urandom_range(0, 19) == 0) put_event(rand_event());
      put_event(ev_chunk(pick_chunk_len(i == nblk)));
      tries = 0;
      repeat ($urandom_range(0, 3)) begin
        if ($urandom_range(0, 1)) begin
          put_event(ev_timeout());
          tries++;
          if (tries >= retry_limit_cfg) return;
        end else begin
          put_event(ev_packet(OPC_ACK, 16'($urandom_range(0, blk - 1))));
          tries = 0;
        end
      end
      case ($urandom_range(0, 24))
        0: begin
          put_event(ev_packet(OPC_ERROR, 16'($urandom)));
          return;
        end
        1: begin
          put_event(ev_packet(OPC_ACK, 16'($urandom_range(blk + 1, 65535))));
          return;
        end
        2: begin
          put_event(ev_packet(other_opcode(OPC_ACK), blk));
          return;
        end
        3: begin
          // run the peer silent until the retry limit gives up
          do begin
            put_event(ev_timeout());
            tries++;
          end while (tries < retry_limit_cfg);
          return;
        end
        default: put_event(ev_packet(OPC_ACK, blk));
      endcase
      blk++;
    end
  endtask

  // Write transfer: in-order DATA with old blocks, timeouts, noise and aborts.
  task automatic write_session();
    logic [15:0] blk;
    int unsigned nblk;
    int unsigned tries;
    bit          ok;
    ok = ($urandom_range(0, 9) != 0);
    put_event(ev_request(OPC_WRQ, ok));
    if (!ok) return;
    blk   = FIRST_BLOCK;
    nblk  = $urandom_range(1, 5);
    tries = 0;
    for (int i = 1; i <= nblk; i++) begin
      if ($urandom_range(0, 5) == 0) begin
        put_event(ev_timeout());
        tries++;
        if (tries >= retry_limit_cfg) return;
      end
      // an old block is dropped silently
      if ($urandom_range(0, 5) == 0)
        put_event(ev_data(16'($urandom_range(0, blk - 1)), pick_packet_len($urandom_range(0, 1))));
      if ($urandom_range(0, 19) == 0) put_event(rand_event());
      case ($urandom_range(0, 24))
        0: begin
          put_event(ev_packet(OPC_ERROR, 16'($urandom)));
          return;
        end
        1: begin
          put_event(ev_data(16'($urandom_range(blk + 1, 65535)), pick_packet_len(1'b0)));
          return;
        end
        2: begin
          put_event(ev_packet(other_opcode(OPC_DATA), blk));
          return;
        end
        3: begin
          do begin
            put_event(ev_timeout());
            tries++;
          end while (tries < retry_limit_cfg);
          return;
        end
        default: begin
          put_event(ev_data(blk, pick_packet_len(i == nblk)));
          tries = 0;
        end
      endcase
      blk++;
    end
  endtask

  // Mostly well-formed transfers, with bursts of raw noise in between.
  task automatic run_sessions(int unsigned count);
    int unsigned stop_at;
    stop_at = events_sent + count;
    while (events_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1:          repeat ($urandom_range(1, 4)) put_event(rand_event());
        2, 3, 4, 5:    read_session();
        default:       write_session();
      endcase
    end
  endtask

  // Extremes of every field, every event kind and each special case.
  task automatic directed_events();
    put_event({OP_UNUSED, 8'($urandom), 16'($urandom), 10'($urandom), 10'($urandom),
               1'($urandom)});
    put_event(ev_packet(OPC_ACK, 16'd7));                // dropped while idle
    put_event(ev_timeout());                             // dropped while idle
    put_event(ev_chunk(10'd300));                        // dropped while idle
    put_event(ev_packet(OPC_DATA, FIRST_BLOCK));         // bad opcode while idle
    put_event(ev_packet(8'hFF, 16'hFFFF));
    put_event(ev_request(OPC_RRQ, 1'b0));                // missing file
    put_event(ev_request(OPC_WRQ, 1'b0));
    // read: oversized chunk, duplicate ACK, short final chunk, resend on timeout
    put_event(ev_request(OPC_RRQ, 1'b1));
    put_event(ev_packet(OPC_DATA, FIRST_BLOCK));         // dropped while awaiting chunk
    put_event(ev_chunk(10'h3FF));
    put_event(ev_packet(OPC_ACK, 16'd0));
    put_event(ev_packet(OPC_ACK, 16'd1));
    put_event(ev_chunk(10'd0));
    put_event(ev_timeout());
    put_event(ev_packet(OPC_ACK, 16'd2));
    // write: oversized packet, old block, silent timeout, far future block
    put_event(ev_request(OPC_WRQ, 1'b1));
    put_event(ev_data(16'd1, 10'h3FF));
    put_event(ev_data(16'd0, FULL_PACKET));
    put_event(ev_timeout());
    put_event(ev_data(16'hFFFF, FULL_PACKET));
    // write ending on a packet shorter than its header: three beats at once
    put_event(ev_request(OPC_WRQ, 1'b1));
    put_event(ev_data(16'd1, 10'd2));
    // peer error while the file is being read
    put_event(ev_request(OPC_RRQ, 1'b1));
    put_event(ev_packet(OPC_ERROR, 16'd0));
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random ready with stall bursts, plus one long hold on request.
  // ---------------------------------------------------------------------------
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request     = 1'b0;
        receiver_holding = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        receiver_holding = 1'b0;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned waited;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    events_sent     = 0;
    send_gap_pct    = 0;
    stall_pct       = 0;
    retry_limit_cfg = RETRY_LIMIT_RST;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed beats at the reset retry limit, some gaps and stalls
    send_gap_pct = 20;
    stall_pct    = 20;
    directed_events();

    // most patient retry limit
    set_retry_limit(4'd15);
    send_gap_pct = 25;
    stall_pct    = 25;
    run_sessions(80);

    // Long hold-off: flood duplicate ACKs so the queue fills and input stalls.
    settle();
    send_gap_pct = 0;
    hold_request = 1'b1;
    wait (receiver_holding);
    put_event(ev_packet(OPC_ERROR, 16'($urandom)));      // force idle whatever came before
    put_event(ev_request(OPC_RRQ, 1'b1));
    put_event(ev_chunk(BLOCK_BYTES));
    repeat (24) put_event(ev_packet(OPC_ACK, 16'd0));
    put_event(ev_packet(OPC_ACK, FIRST_BLOCK));
    put_event(ev_chunk(10'd5));
    put_event(ev_packet(OPC_ACK, 16'd2));
    // pause the sender until every result is out
    settle();

    // least patient nonzero limit, back-to-back events against heavy stalls
    set_retry_limit(4'd1);
    send_gap_pct = 0;
    stall_pct    = 40;
    run_sessions(50);

    // zero limit: the first timeout while awaiting an ACK or receiving data aborts the transfer
    set_retry_limit(4'd0);
    send_gap_pct = 30;
    stall_pct    = 10;
    run_sessions(25);

    set_retry_limit(4'($urandom_range(2, 14)));
    send_gap_pct = 50;
    stall_pct    = 0;
    run_sessions(45);

    set_retry_limit(4'd15);
    send_gap_pct = 0;
    stall_pct    = 0;

    // closing stretch with no idling on either side
    run_sessions(40);

    // Drain: wait for the last predicted beats, then watch for strays.
    in_valid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (actions_pending != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    if (actions_pending != 0) $error("%0d result beats never arrived", actions_pending);
    if (mismatch_count == 0 && actions_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
